// ----- rtl/pws_pkg.sv -----
// Shared constants, types and codes of the latency window monitor.
package pws_pkg;

  localparam int NUM_CLIENTS = 256;
  localparam int MAX_WINDOW  = 64;
  localparam int CLIENT_W    = $clog2(NUM_CLIENTS);
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int LAT_W       = 16;
  localparam int WF_W        = 7;
  localparam int ACC_W       = LAT_W + SLOT_W;
  localparam int ADDR_W      = CLIENT_W + SLOT_W;
  localparam int DIV_CNT_W   = $clog2(ACC_W + 1);

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // One queued item.
  typedef struct packed {
    logic              action;
    logic [CLIENT_W-1:0] client;
    logic [LAT_W-1:0]  latency;
  } item_t;

  // Per-client bookkeeping word.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] newest;
    logic [LAT_W-1:0]  average;
    logic [LAT_W-1:0]  fluct;
  } meta_t;

endpackage

// ----- rtl/pws_front.sv -----
// Front end: accepts items into a two-entry queue for the back end.
module pws_front import pws_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  item_t item_in,
  output logic  busy,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = q[rd_ptr];
  assign push       = start && !busy;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && head_valid) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop && head_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/pws_div.sv -----
// Restoring divider that divides two sums by one small divisor, a bit a cycle.
module pws_div import pws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] num_a,
  input  logic [ACC_W-1:0] num_b,
  input  logic [CNT_W-1:0] den,
  output logic             done,
  output logic [ACC_W-1:0] quo_a,
  output logic [ACC_W-1:0] quo_b
);

  logic [CNT_W-1:0]     rem_a;
  logic [CNT_W-1:0]     rem_b;
  logic [CNT_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] steps;
  logic                 running;
  logic [CNT_W:0]       trial_a;
  logic [CNT_W:0]       trial_b;
  logic                 ge_a;
  logic                 ge_b;

  // One trial subtraction per quotient bit.
  always_comb begin
    trial_a = {rem_a, quo_a[ACC_W-1]};
    trial_b = {rem_b, quo_b[ACC_W-1]};
    ge_a    = (trial_a >= {1'b0, dvs});
    ge_b    = (trial_b >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= '0;
        quo_a   <= num_a;
        quo_b   <= num_b;
        rem_a   <= '0;
        rem_b   <= '0;
        dvs     <= den;
      end else if (running) begin
        rem_a <= ge_a ? CNT_W'(trial_a - {1'b0, dvs}) : trial_a[CNT_W-1:0];
        rem_b <= ge_b ? CNT_W'(trial_b - {1'b0, dvs}) : trial_b[CNT_W-1:0];
        quo_a <= {quo_a[ACC_W-2:0], ge_a};
        quo_b <= {quo_b[ACC_W-2:0], ge_b};
        steps <= steps + DIV_CNT_W'(1);
        if (steps == DIV_CNT_W'(ACC_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/pws_back.sv -----
// Back end: walks a client's window, computes its statistics and updates stores.
module pws_back import pws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [CNT_W-1:0]    wf,
  input  logic                head_valid,
  input  item_t               head,
  output logic                pop,
  output logic                done,
  output logic [CLIENT_W-1:0] client_out,
  output logic [LAT_W-1:0]    avg_out,
  output logic [LAT_W-1:0]    fluct_out,
  output logic                ready_out
);

  typedef enum logic [2:0] {S_IDLE, S_META, S_WALK, S_DIV, S_UPD} state_t;

  state_t               state;
  item_t                cur;
  logic [LAT_W-1:0]     sample_mem [NUM_CLIENTS*MAX_WINDOW];
  meta_t                meta_mem [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] meta_valid;
  meta_t                meta_q;
  logic                 meta_vq;
  meta_t                meta;
  logic [LAT_W-1:0]     sample_q;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_vld;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     new_cnt;
  logic [SLOT_W-1:0]    newest;
  logic [CNT_W-1:0]     issue_k;
  logic [CNT_W-1:0]     acc_k;
  logic [ACC_W-1:0]     sum;
  logic [ACC_W-1:0]     fl_sum;
  logic [LAT_W-1:0]     newer;
  logic [LAT_W-1:0]     diff;
  logic [LAT_W-1:0]     avg;
  logic [LAT_W-1:0]     fl;
  logic                 rdy;
  logic                 div_start;
  logic                 div_done;
  logic [ACC_W-1:0]     quo_a;
  logic [ACC_W-1:0]     quo_b;
  logic                 meta_we;
  meta_t                meta_wd;
  logic                 meta_wv;

  assign pop  = (state == S_IDLE) && head_valid;
  assign meta = meta_vq ? meta_q : '0;
  assign diff = (newer > sample_q) ? newer - sample_q : sample_q - newer;

  // Window read address: the sample issue_k places older than the newest.
  assign rd_en   = (state == S_WALK) && (issue_k < cnt);
  assign rd_addr = {cur.client, SLOT_W'(newest - issue_k[SLOT_W-1:0])};

  // Meta write on a clear and at the end of an add.
  always_comb begin
    meta_we = 1'b0;
    meta_wv = 1'b0;
    meta_wd = '0;
    if (pop && head.action == ACT_CLEAR) begin
      meta_we = 1'b1;
    end else if (state == S_UPD) begin
      meta_we = 1'b1;
      meta_wv = 1'b1;
      meta_wd = '{count: new_cnt, newest: SLOT_W'(newest + SLOT_W'(1)),
                  average: avg, fluct: fl};
    end
  end

  // Sample memory.
  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      sample_mem[{cur.client, SLOT_W'(newest + SLOT_W'(1))}] <= cur.latency;
    end
    if (rd_en) begin
      sample_q <= sample_mem[rd_addr];
    end
  end

  // Per-client bookkeeping memory.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[pop ? head.client : cur.client] <= meta_wd;
    end
    if (pop) begin
      meta_q <= meta_mem[head.client];
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_valid <= '0;
    end else begin
      if (meta_we) begin
        meta_valid[pop ? head.client : cur.client] <= meta_wv;
      end
      if (pop) begin
        meta_vq <= meta_valid[head.client];
      end
    end
  end

  pws_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (sum),
    .num_b (fl_sum),
    .den   (cnt),
    .done  (div_done),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  // Sequencer with registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      rd_vld    <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      rd_vld    <= rd_en;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= head;
            if (head.action == ACT_CLEAR) begin
              done       <= 1'b1;
              client_out <= head.client;
              avg_out    <= '0;
              fluct_out  <= '0;
              ready_out  <= 1'b0;
            end else begin
              state <= S_META;
            end
          end
        end
        S_META: begin
          cnt     <= meta.count;
          newest  <= meta.newest;
          new_cnt <= (meta.count >= wf) ? wf : meta.count + CNT_W'(1);
          issue_k <= '0;
          acc_k   <= '0;
          sum     <= '0;
          fl_sum  <= '0;
          newer   <= '0;
          if (meta.count >= wf && meta.count != '0) begin
            state <= S_WALK;
          end else begin
            avg   <= meta.average;
            fl    <= meta.fluct;
            rdy   <= 1'b0;
            state <= S_UPD;
          end
        end
        S_WALK: begin
          if (rd_en) begin
            issue_k <= issue_k + CNT_W'(1);
          end
          if (rd_vld) begin
            sum   <= sum + ACC_W'(sample_q);
            if (newer != '0) begin
              fl_sum <= fl_sum + ACC_W'(diff);
            end
            newer <= sample_q;
            acc_k <= acc_k + CNT_W'(1);
            if (acc_k == cnt - CNT_W'(1)) begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            avg   <= quo_a[LAT_W-1:0];
            fl    <= quo_b[LAT_W-1:0];
            rdy   <= 1'b1;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          done       <= 1'b1;
          client_out <= cur.client;
          avg_out    <= avg;
          fluct_out  <= fl;
          ready_out  <= rdy;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ping_window_stats.sv -----
// Top level of the per-client latency window monitor.
// Usage: drive start with action, client_index and latency_ms; the item is
// taken at a clock edge where start is high and busy is low. Up to two items
// wait in a queue while the back end works, and busy is high when it is full.
// Each item gives exactly one result: done is high for one cycle with
// client_index_out, average_latency, latency_fluctuation and stats_ready.
// The receiver cannot stall; results simply appear.
// A clear item gives its result straight from the idle state. An add item on
// a window that is not full goes through the meta read and the update state.
// On a full window of N samples the back end makes N window reads from the
// sample memory, one per cycle, then a 22-step shared divider, then the update.
// Items are worked one at a time by the back end, which takes the next queued
// item in the cycle in which done is high.
// window_frames_we writes window_frames (reset value 30); write it while idle.
// Reset clears the queue, the sequencer and the per-client valid bits, so all
// clients start with empty windows and zero statistics.
module ping_window_stats import pws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                action,
  input  logic [CLIENT_W-1:0] client_index,
  input  logic [LAT_W-1:0]    latency_ms,
  input  logic                window_frames_we,
  input  logic [WF_W-1:0]     window_frames,
  output logic                done,
  output logic [CLIENT_W-1:0] client_index_out,
  output logic [LAT_W-1:0]    average_latency,
  output logic [LAT_W-1:0]    latency_fluctuation,
  output logic                stats_ready
);

  logic [WF_W-1:0]  wf_reg;
  logic [CNT_W-1:0] wf_eff;
  item_t            item_in;
  item_t            head;
  logic             head_valid;
  logic             pop;

  // Window length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wf_reg <= WF_W'(30);
    end else if (window_frames_we) begin
      wf_reg <= window_frames;
    end
  end

  // Clamp the window length to 1..MAX_WINDOW.
  always_comb begin
    if (wf_reg == '0) begin
      wf_eff = CNT_W'(1);
    end else if (CNT_W'(wf_reg) > CNT_W'(MAX_WINDOW)) begin
      wf_eff = CNT_W'(MAX_WINDOW);
    end else begin
      wf_eff = CNT_W'(wf_reg);
    end
  end

  assign item_in = '{action: action, client: client_index, latency: latency_ms};

  pws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item_in    (item_in),
    .busy       (busy),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wf         (wf_eff),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .done       (done),
    .client_out (client_index_out),
    .avg_out    (average_latency),
    .fluct_out  (latency_fluctuation),
    .ready_out  (stats_ready)
  );

endmodule
